// File: src/lagrange_interpolation_eval_defines.svh
// Assertion macros shared by the Lagrange evaluator modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef LAGRANGE_INTERPOLATION_EVAL_DEFINES_SVH
`define LAGRANGE_INTERPOLATION_EVAL_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define LIE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define LIE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: src/lie_pkg.sv
// Package for the Lagrange evaluator: types and fixed-point constants.
// No dependencies.
`timescale 1ns / 1ps
package lie_pkg;
   localparam int unsigned QFrac = 24;
   localparam logic signed [31:0] QOne = 32'sd16777216;
   localparam logic signed [31:0] SMax = 32'sh7FFFFFFF;
   localparam logic signed [31:0] SMin = 32'sh80000000;

   typedef enum logic [2:0] {
      OP_NONE, OP_NUM, OP_DEN, OP_DIV, OP_TERM, OP_CLEAR
   } op_type;

   // Controller to datapath.
   typedef struct packed {
      op_type     op;
      logic       sel_num;     // difference operand is point minus x_j
      logic       load_xi;     // capture read data as x_i
      logic       skip;        // operand pair is discarded
      logic       div_start;
   } cmd_type;

   typedef struct packed {
      logic       same_x;      // read x_j equals x_i
      logic       div_busy;
   } status_type;

   function automatic logic signed [31:0] clip64(input logic signed [64:0] v,
                                                 output logic sat);
      begin
         sat = 1'b0;
         if (v > 65'sd2147483647) begin
            sat = 1'b1;
            clip64 = SMax;
         end else if (v < -65'sd2147483648) begin
            sat = 1'b1;
            clip64 = SMin;
         end else begin
            clip64 = v[31:0];
         end
      end
   endfunction
endpackage

// File: src/lie_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface lie_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: src/lagrange_interpolation_eval.sv
// Lagrange evaluator. A load with an in-range index writes both node tables. An
// evaluation over N nodes raises rsp.valid once it has, per node, fetched x_i, run
// each node pair through the shared multiplier, run the 56-step divider and added
// the term. One item at a time; the result waits in an output register and the next
// item is taken the cycle after it leaves.
// Synchronous active-high reset: node count 1, tables undefined until written.
`timescale 1ns / 1ps
module lagrange_interpolation_eval #(
   parameter int MAX_NODES = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [4:0] csr_wdata,
   lie_if.sink        req,
   lie_if.source      rsp
);
   localparam int IW = $clog2(MAX_NODES);
   logic [4:0] count_ff;
   logic [IW:0] n_eff;
   lie_pkg::cmd_type cmd;
   lie_pkg::status_type status;
   logic [IW-1:0] rd_addr;
   logic ctl_busy, done, start, req_fire, wr_en, r_sat;
   logic signed [31:0] point_ff, r_val;
   logic rsp_valid_ff;
   logic signed [31:0] rsp_val_ff;
   logic rsp_sat_ff;

   assign req.ready = !ctl_busy && !rsp_valid_ff;
   assign req_fire = req.valid && req.ready;
   assign start = req_fire && req.payload.kind;
   assign wr_en = req_fire && !req.payload.kind
                  && (32'(req.payload.node_index) < 32'(MAX_NODES));
   always_comb begin
      if (32'(count_ff) > 32'(MAX_NODES)) n_eff = (IW+1)'(MAX_NODES);
      else n_eff = (IW+1)'(count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 5'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) count_ff <= csr_wdata;
         if (done) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
      if (start) point_ff <= req.payload.point_x;
      if (done) begin
         rsp_val_ff <= r_val;
         rsp_sat_ff <= r_sat;
      end
   end

   lie_controller #(.MaxNodes(MAX_NODES)) u_ctl (
      .clock(clock), .reset(reset), .start(start), .count(n_eff),
      .status(status), .cmd(cmd), .rd_addr(rd_addr), .busy(ctl_busy),
      .done(done));
   lie_datapath #(.MaxNodes(MAX_NODES)) u_dp (
      .clock(clock), .reset(reset), .wr_en(wr_en),
      .wr_addr(IW'(req.payload.node_index)), .wr_x(req.payload.point_x),
      .wr_y(req.payload.node_value), .rd_addr(rd_addr), .point_x(point_ff),
      .cmd(cmd), .status(status), .result(r_val), .result_sat(r_sat));

   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload.interp_value = rsp_val_ff;
   assign rsp.payload.saturated = rsp_sat_ff;
endmodule

// File: src/lie_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`timescale 1ns / 1ps
module lie_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: src/lie_divider.sv
// Restoring divider, one quotient bit a cycle: (num << 24) / den, truncated.
// Uses lie_pkg.
`timescale 1ns / 1ps
module lie_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   output logic               busy,
   output logic signed [31:0] quot,
   output logic               sat
);
   logic [55:0] dividend_ff, dividend_in;
   logic [31:0] divisor_ff, divisor_in;
   logic [32:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in, busy_ff, busy_in;
   logic [33:0] trial;
   logic [56:0] q_signed;
   logic        s;

   always_comb begin
      dividend_in = dividend_ff;
      divisor_in = divisor_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      busy_in = busy_ff;
      trial = '0;
      if (start) begin
         dividend_in = {(num[31] ? 32'(-num) : 32'(num)), 24'd0};
         divisor_in = den[31] ? 32'(-den) : 32'(den);
         rem_in = '0;
         cnt_in = 6'd56;
         neg_in = num[31] ^ den[31];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, dividend_ff[55]} - {2'b00, divisor_ff};
         if (!trial[33]) rem_in = trial[32:0];
         else rem_in = {rem_ff[31:0], dividend_ff[55]};
         dividend_in = {dividend_ff[54:0], ~trial[33]};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      dividend_ff <= dividend_in;
      divisor_ff <= divisor_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   assign busy = busy_ff;
   assign q_signed = neg_ff ? 57'(-{1'b0, dividend_ff}) : {1'b0, dividend_ff};
   always_comb quot = lie_pkg::clip64(65'(signed'(q_signed)), s);
   assign sat = s;
endmodule

// File: src/lie_datapath.sv
// Datapath: node tables, difference, shared multiplier, divider and sum.
// Uses lie_pkg, lie_ram and lie_divider.
`timescale 1ns / 1ps
`include "lagrange_interpolation_eval_defines.svh"
module lie_datapath #(
   parameter int MaxNodes = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [$clog2(MaxNodes)-1:0] wr_addr,
   input  logic signed [31:0]          wr_x,
   input  logic signed [31:0]          wr_y,
   input  logic [$clog2(MaxNodes)-1:0] rd_addr,
   input  logic signed [31:0]          point_x,
   input  lie_pkg::cmd_type            cmd,
   output lie_pkg::status_type         status,
   output logic signed [31:0]          result,
   output logic                        result_sat
);
   logic signed [31:0] rx, ry, xi_ff, num_ff, num_in, den_ff, den_in;
   logic signed [31:0] diff, mul_a, mul_b, prod_c, quot, ratio_ff, ratio_in;
   logic signed [36+31:0] acc_ff, acc_in;
   logic sat_ff, sat_in, s_d, s_p, s_q, s_r, busy;
   logic signed [63:0] prod;
   logic signed [64:0] shifted;

   lie_ram #(.Width(32), .Depth(MaxNodes)) u_xram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_x),
      .rd_addr(rd_addr), .rd_data(rx));
   lie_ram #(.Width(32), .Depth(MaxNodes)) u_yram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_y),
      .rd_addr(rd_addr), .rd_data(ry));
   lie_divider u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start), .num(num_ff),
      .den(den_ff), .busy(busy), .quot(quot), .sat(s_q));

   always_comb begin
      diff = lie_pkg::clip64(cmd.sel_num ? 65'(point_x) - 65'(rx)
                                         : 65'(xi_ff) - 65'(rx), s_d);
      case (cmd.op)
         lie_pkg::OP_NUM:  begin mul_a = num_ff;   mul_b = diff; end
         lie_pkg::OP_DEN:  begin mul_a = den_ff;   mul_b = diff; end
         lie_pkg::OP_TERM: begin mul_a = ratio_ff; mul_b = ry;   end
         default:          begin mul_a = '0;       mul_b = '0;   end
      endcase
      prod = 64'(mul_a) * 64'(mul_b);
      shifted = 65'(prod >>> lie_pkg::QFrac);  // floor
      prod_c = lie_pkg::clip64(shifted, s_p);
      // Zero denominator gives the saturated limit with the numerator's sign, or zero for a zero numerator.
      if (den_ff == '0) begin
         s_r = (num_ff != '0);
         ratio_in = num_ff[31] ? lie_pkg::SMin
                  : (num_ff == '0 ? 32'sd0 : lie_pkg::SMax);
      end else begin
         s_r = s_q;
         ratio_in = quot;
      end
      num_in = num_ff; den_in = den_ff; acc_in = acc_ff; sat_in = sat_ff;
      case (cmd.op)
         lie_pkg::OP_CLEAR: begin
            acc_in = '0; sat_in = 1'b0;
            num_in = lie_pkg::QOne; den_in = lie_pkg::QOne;
         end
         lie_pkg::OP_NUM: if (!cmd.skip) begin
            num_in = prod_c; sat_in = sat_ff | s_d | s_p;
         end
         lie_pkg::OP_DEN: if (!cmd.skip) begin
            den_in = prod_c; sat_in = sat_ff | s_d | s_p;
         end
         lie_pkg::OP_DIV: sat_in = sat_ff | s_r;
         lie_pkg::OP_TERM: begin
            acc_in = acc_ff + 68'(prod_c); sat_in = sat_ff | s_p;
            num_in = lie_pkg::QOne; den_in = lie_pkg::QOne;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_ff <= 1'b0;
         acc_ff <= '0;
      end else begin
         sat_ff <= sat_in;
         acc_ff <= acc_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      if (cmd.op == lie_pkg::OP_DIV) ratio_ff <= ratio_in;
      if (cmd.load_xi) xi_ff <= rx;
   end

   logic fs;
   always_comb result = lie_pkg::clip64(65'(acc_ff), fs);
   assign result_sat = sat_ff | fs;
   assign status.same_x = (rx == xi_ff);
   assign status.div_busy = busy;

   `LIE_ASSERT_NEXT(a_clear_sum, clock, reset, cmd.op == lie_pkg::OP_CLEAR, acc_ff == '0)
   `LIE_ASSERT_NEXT(a_div_busy, clock, reset, cmd.div_start, busy)
   `LIE_ASSERT_IMP(a_no_restart, clock, reset, busy, !cmd.div_start)
endmodule

// File: src/lie_controller.sv
// Controller: sequences table reads, products, divide and sum per evaluation.
// Uses lie_pkg.
`timescale 1ns / 1ps
`include "lagrange_interpolation_eval_defines.svh"
module lie_controller #(
   parameter int MaxNodes = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [$clog2(MaxNodes):0]   count,
   input  lie_pkg::status_type         status,
   output lie_pkg::cmd_type            cmd,
   output logic [$clog2(MaxNodes)-1:0] rd_addr,
   output logic                        busy,
   output logic                        done
);
   localparam int IW = $clog2(MaxNodes);
   typedef enum logic [3:0] {
      S_IDLE, S_RDI, S_XI, S_RDJ, S_NUM, S_DEN, S_DSTART, S_DWAIT, S_DIV,
      S_RDY, S_TERM, S_DONE
   } state_type;
   state_type state_ff;
   logic [IW:0] i_ff, j_ff;
   logic        done_ff;

   always_comb begin
      cmd = '0;
      rd_addr = IW'(i_ff);
      case (state_ff)
         S_IDLE: if (start) cmd.op = lie_pkg::OP_CLEAR;
         S_XI: cmd.load_xi = 1'b1;
         S_RDJ: rd_addr = IW'(j_ff);
         S_NUM: begin
            rd_addr = IW'(j_ff);
            cmd.op = lie_pkg::OP_NUM; cmd.sel_num = 1'b1;
            cmd.skip = status.same_x;
         end
         S_DEN: begin
            rd_addr = IW'(j_ff);
            cmd.op = lie_pkg::OP_DEN; cmd.skip = status.same_x;
         end
         S_DSTART: cmd.div_start = 1'b1;
         S_DIV: cmd.op = lie_pkg::OP_DIV;
         S_TERM: cmd.op = lie_pkg::OP_TERM;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         i_ff <= '0; j_ff <= '0; done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (start) begin
               i_ff <= '0;
               state_ff <= (count == '0) ? S_DONE : S_RDI;
            end
            S_RDI: state_ff <= S_XI;
            S_XI: begin j_ff <= '0; state_ff <= S_RDJ; end
            S_RDJ: state_ff <= S_NUM;
            S_NUM: state_ff <= S_DEN;
            S_DEN: if (j_ff + 1'b1 == count) state_ff <= S_DSTART;
               else begin j_ff <= j_ff + 1'b1; state_ff <= S_RDJ; end
            S_DSTART: state_ff <= S_DWAIT;
            S_DWAIT: if (!status.div_busy) state_ff <= S_DIV;
            S_DIV: state_ff <= S_RDY;
            S_RDY: state_ff <= S_TERM;
            S_TERM: if (i_ff + 1'b1 == count) state_ff <= S_DONE;
               else begin i_ff <= i_ff + 1'b1; state_ff <= S_RDI; end
            S_DONE: begin done_ff <= 1'b1; state_ff <= S_IDLE; end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE) || done_ff;
   assign done = done_ff;

   `LIE_ASSERT_IMP(a_j_range, clock, reset, state_ff == S_NUM, j_ff < count)
   `LIE_ASSERT_IMP(a_i_range, clock, reset, state_ff == S_TERM, i_ff < count)
   `LIE_ASSERT_NEXT(a_done_idle, clock, reset, done_ff, state_ff == S_IDLE)
endmodule
